// File: hdl/msa_pkg.sv
// Shared types and constants of the minimum arborescence solver.
package msa_pkg;

  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 1024;
  localparam int NodeW     = 6;
  localparam int CntW      = NodeW + 1;
  localparam int EdgeAddrW = $clog2(MaxEdges);
  localparam int EdgeCntW  = EdgeAddrW + 1;
  localparam int WeightW   = 32;
  localparam int CostW     = 48;
  localparam int PaddrW    = 3;

  localparam logic [EdgeCntW-1:0] MaxEdgeCnt = EdgeCntW'(MaxEdges);
  localparam logic [CntW-1:0]     MaxNodeCnt = CntW'(MaxNodes);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                      command;
    logic [NodeW-1:0]          edge_source;
    logic [NodeW-1:0]          edge_target;
    logic signed [WeightW-1:0] edge_weight;
    logic [NodeW-1:0]          root_node;
  } in_item_t;

  typedef struct packed {
    logic signed [CostW-1:0] total_cost;
    logic                    unreachable;
    logic                    edges_dropped;
  } out_item_t;

  typedef struct packed {
    logic [NodeW-1:0]   tail;
    logic [NodeW-1:0]   head;
    logic [WeightW-1:0] weight;
  } edge_rec_t;

  typedef struct packed {
    logic [NodeW-1:0] tail;
    logic [NodeW-1:0] head;
    logic [CostW-1:0] weight;
  } work_rec_t;

  typedef struct packed {
    logic [CostW-1:0] in_w;
    logic             has_in;
    logic [NodeW-1:0] pre;
    logic             id_v;
    logic [NodeW-1:0] id;
    logic             vis_v;
    logic [NodeW-1:0] vis;
  } node_rec_t;

endpackage

// File: hdl/msa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module msa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/minimum_arborescence_solver_top.sv
// Minimum-cost arborescence solver: edge store, working edge copy and node table in RAMs.
// Add edge: one transfer per cycle while idle, stored at the accepting edge unless the edge store is full.
// Solve: copies the m stored edges, then runs k contraction rounds (k < n, n nodes); each round
//   finds the cheapest in-edge per node, walks from every node and labels cycle members,
//   then, if a cycle was found, relabels the nodes and rewrites the working edges.
// No input is taken during a solve; the result register frees the output side.
// Reset clears the edge count, the overflow flag and sets node_count to 1; RAMs are not cleared.
module minimum_arborescence_solver_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  msa_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output msa_pkg::out_item_t                   out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [msa_pkg::PaddrW-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_COPY_RD    = 5'd1;
  localparam logic [4:0] S_COPY_WR    = 5'd2;
  localparam logic [4:0] S_INIT       = 5'd3;
  localparam logic [4:0] S_MIN_RD     = 5'd4;
  localparam logic [4:0] S_MIN_EDGE   = 5'd5;
  localparam logic [4:0] S_MIN_CMP    = 5'd6;
  localparam logic [4:0] S_WALK_START = 5'd7;
  localparam logic [4:0] S_WALK_CHK   = 5'd8;
  localparam logic [4:0] S_CYC        = 5'd9;
  localparam logic [4:0] S_RELAB_RD   = 5'd10;
  localparam logic [4:0] S_RELAB_WR   = 5'd11;
  localparam logic [4:0] S_EDGE_RD    = 5'd12;
  localparam logic [4:0] S_EDGE_U     = 5'd13;
  localparam logic [4:0] S_EDGE_V     = 5'd14;
  localparam logic [4:0] S_EDGE_WR    = 5'd15;
  localparam logic [4:0] S_ROOT_RD    = 5'd16;
  localparam logic [4:0] S_ROOT_WR    = 5'd17;
  localparam logic [4:0] S_DONE       = 5'd18;

  logic [4:0]                      state_q, state_d;
  logic [msa_pkg::CntW-1:0]        node_count_q, node_count_d;
  logic [msa_pkg::EdgeCntW-1:0]    edge_total_q, edge_total_d;
  logic                            ovf_q, ovf_d;
  logic [msa_pkg::EdgeCntW-1:0]    e_q, e_d;
  logic [msa_pkg::CntW-1:0]        i_q, i_d;
  logic [msa_pkg::CntW-1:0]        n_q, n_d;
  logic [msa_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [msa_pkg::NodeW-1:0]       v_q, v_d;
  logic [msa_pkg::NodeW-1:0]       u_q, u_d;
  logic [msa_pkg::NodeW-1:0]       root_q, root_d;
  logic [msa_pkg::NodeW-1:0]       idu_q, idu_d;
  logic [msa_pkg::CostW-1:0]       res_q, res_d;
  logic                            fail_q, fail_d;
  logic                            first_q, first_d;
  msa_pkg::work_rec_t              wrk_q, wrk_d;
  logic                            out_valid_q, out_valid_d;
  msa_pkg::out_item_t              out_data_q, out_data_d;

  logic                            edge_we;
  msa_pkg::edge_rec_t              edge_wdata, edge_rdata;
  logic                            work_we;
  msa_pkg::work_rec_t              work_wdata, work_rdata;
  logic                            node_we;
  logic [msa_pkg::NodeW-1:0]       node_waddr, node_raddr;
  msa_pkg::node_rec_t              node_wdata, node_rdata;

  logic                            in_acc;
  logic                            cfg_wr;
  logic [msa_pkg::CntW-1:0]        n_eff;
  logic                            e_last, i_last;
  logic                            not_root, free_node, cp_ok;
  logic                            adv_min, adv_walk;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == msa_pkg::REG_NODE_COUNT);
  assign prdata = (paddr[2] == msa_pkg::REG_NODE_COUNT) ? {25'd0, node_count_q} : 32'd0;

  assign in_ready_o = (state_q == S_IDLE) &&
                      (!out_valid_q || out_ready_i || in_data_i.command == msa_pkg::CMD_ADD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign n_eff = (node_count_q == '0) ? msa_pkg::CntW'(1) :
                 (node_count_q > msa_pkg::MaxNodeCnt) ? msa_pkg::MaxNodeCnt : node_count_q;
  assign e_last = (e_q + msa_pkg::EdgeCntW'(1)) == edge_total_q;
  assign i_last = (i_q + msa_pkg::CntW'(1)) == n_q;
  assign not_root  = v_q != root_q;
  assign free_node = !node_rdata.id_v;
  assign cp_ok = ({1'b0, edge_rdata.tail} < n_q) && ({1'b0, edge_rdata.head} < n_q);

  msa_ram #(.Width($bits(msa_pkg::edge_rec_t)), .Depth(msa_pkg::MaxEdges)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[msa_pkg::EdgeAddrW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (e_q[msa_pkg::EdgeAddrW-1:0]),
    .rdata_o (edge_rdata)
  );

  msa_ram #(.Width($bits(msa_pkg::work_rec_t)), .Depth(msa_pkg::MaxEdges)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (e_q[msa_pkg::EdgeAddrW-1:0]),
    .wdata_i (work_wdata),
    .raddr_i (e_q[msa_pkg::EdgeAddrW-1:0]),
    .rdata_o (work_rdata)
  );

  msa_ram #(.Width($bits(msa_pkg::node_rec_t)), .Depth(msa_pkg::MaxNodes)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  always_comb begin
    state_d      = state_q;
    node_count_d = cfg_wr ? pwdata[msa_pkg::CntW-1:0] : node_count_q;
    edge_total_d = edge_total_q;
    ovf_d        = ovf_q;
    e_d          = e_q;
    i_d          = i_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    v_d          = v_q;
    u_d          = u_q;
    root_d       = root_q;
    idu_d        = idu_q;
    res_d        = res_q;
    fail_d       = fail_q;
    first_d      = first_q;
    wrk_d        = wrk_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    adv_min      = 1'b0;
    adv_walk     = 1'b0;

    edge_we           = 1'b0;
    edge_wdata.tail   = in_data_i.edge_source;
    edge_wdata.head   = in_data_i.edge_target;
    edge_wdata.weight = in_data_i.edge_weight;
    work_we    = 1'b0;
    work_wdata = wrk_q;
    node_we    = 1'b0;
    node_waddr = v_q;
    node_wdata = node_rdata;
    node_raddr = v_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == msa_pkg::CMD_ADD) begin
            if (edge_total_q < msa_pkg::MaxEdgeCnt) begin
              edge_we      = 1'b1;
              edge_total_d = edge_total_q + msa_pkg::EdgeCntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            n_d    = n_eff;
            root_d = in_data_i.root_node;
            res_d  = '0;
            fail_d = 1'b0;
            e_d    = '0;
            i_d    = '0;
            cnt_d  = '0;
            if ({1'b0, in_data_i.root_node} >= n_eff) begin
              fail_d  = 1'b1;
              state_d = S_DONE;
            end else if (edge_total_q == '0) begin
              state_d = S_INIT;
            end else begin
              state_d = S_COPY_RD;
            end
          end
        end
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        // out-of-range edges become self loops so the minimum-edge pass skips them
        work_we           = 1'b1;
        work_wdata.tail   = cp_ok ? edge_rdata.tail : '0;
        work_wdata.head   = cp_ok ? edge_rdata.head : '0;
        work_wdata.weight = {{(msa_pkg::CostW - msa_pkg::WeightW){edge_rdata.weight[31]}},
                             edge_rdata.weight};
        e_d = e_q + msa_pkg::EdgeCntW'(1);
        if (e_last) begin
          i_d     = '0;
          state_d = S_INIT;
        end else begin
          state_d = S_COPY_RD;
        end
      end
      S_INIT: begin
        node_we    = 1'b1;
        node_waddr = i_q[msa_pkg::NodeW-1:0];
        node_wdata = '0;
        cnt_d      = '0;
        i_d        = i_q + msa_pkg::CntW'(1);
        if (i_last) begin
          i_d     = '0;
          e_d     = '0;
          state_d = (edge_total_q == '0) ? S_WALK_START : S_MIN_RD;
        end
      end
      S_MIN_RD: state_d = S_MIN_EDGE;
      S_MIN_EDGE: begin
        wrk_d = work_rdata;
        if (work_rdata.tail != work_rdata.head) begin
          node_raddr = work_rdata.head;
          state_d    = S_MIN_CMP;
        end else begin
          adv_min = 1'b1;
        end
      end
      S_MIN_CMP: begin
        node_waddr = wrk_q.head;
        if (!node_rdata.has_in || ($signed(wrk_q.weight) < $signed(node_rdata.in_w))) begin
          node_we           = 1'b1;
          node_wdata.in_w   = wrk_q.weight;
          node_wdata.has_in = 1'b1;
          node_wdata.pre    = wrk_q.tail;
        end
        adv_min = 1'b1;
      end
      S_WALK_START: begin
        node_raddr = i_q[msa_pkg::NodeW-1:0];
        v_d        = i_q[msa_pkg::NodeW-1:0];
        first_d    = 1'b1;
        state_d    = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        first_d = 1'b0;
        if (first_q && not_root) begin
          res_d = res_q + node_rdata.in_w;
        end
        if (not_root && free_node && !node_rdata.has_in) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else if (not_root && free_node &&
                     !(node_rdata.vis_v && node_rdata.vis == i_q[msa_pkg::NodeW-1:0])) begin
          // mark and follow the cheapest incoming edge
          node_we          = 1'b1;
          node_wdata.vis_v = 1'b1;
          node_wdata.vis   = i_q[msa_pkg::NodeW-1:0];
          v_d              = node_rdata.pre;
          node_raddr       = node_rdata.pre;
        end else if (not_root && free_node) begin
          // closed a cycle at v: label its members with the next id
          node_we         = 1'b1;
          node_wdata.id_v = 1'b1;
          node_wdata.id   = cnt_q[msa_pkg::NodeW-1:0];
          u_d             = node_rdata.pre;
          node_raddr      = node_rdata.pre;
          state_d         = S_CYC;
        end else begin
          adv_walk = 1'b1;
        end
      end
      S_CYC: begin
        node_waddr      = u_q;
        node_we         = 1'b1;
        node_wdata.id_v = 1'b1;
        node_wdata.id   = cnt_q[msa_pkg::NodeW-1:0];
        if (node_rdata.pre == v_q) begin
          cnt_d    = cnt_q + msa_pkg::CntW'(1);
          adv_walk = 1'b1;
        end else begin
          u_d        = node_rdata.pre;
          node_raddr = node_rdata.pre;
        end
      end
      S_RELAB_RD: begin
        node_raddr = i_q[msa_pkg::NodeW-1:0];
        state_d    = S_RELAB_WR;
      end
      S_RELAB_WR: begin
        node_waddr = i_q[msa_pkg::NodeW-1:0];
        if (!node_rdata.id_v) begin
          node_we         = 1'b1;
          node_wdata.id_v = 1'b1;
          node_wdata.id   = cnt_q[msa_pkg::NodeW-1:0];
          cnt_d           = cnt_q + msa_pkg::CntW'(1);
        end
        i_d = i_q + msa_pkg::CntW'(1);
        if (i_last) begin
          e_d     = '0;
          state_d = (edge_total_q == '0) ? S_ROOT_RD : S_EDGE_RD;
        end else begin
          state_d = S_RELAB_RD;
        end
      end
      S_EDGE_RD: state_d = S_EDGE_U;
      S_EDGE_U: begin
        wrk_d      = work_rdata;
        node_raddr = work_rdata.tail;
        state_d    = S_EDGE_V;
      end
      S_EDGE_V: begin
        idu_d      = node_rdata.id;
        node_raddr = wrk_q.head;
        state_d    = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        work_we           = 1'b1;
        work_wdata.tail   = idu_q;
        work_wdata.head   = node_rdata.id;
        work_wdata.weight = (idu_q != node_rdata.id) ? (wrk_q.weight - node_rdata.in_w)
                                                     : wrk_q.weight;
        e_d = e_q + msa_pkg::EdgeCntW'(1);
        state_d = e_last ? S_ROOT_RD : S_EDGE_RD;
      end
      S_ROOT_RD: begin
        node_raddr = root_q;
        state_d    = S_ROOT_WR;
      end
      S_ROOT_WR: begin
        root_d  = node_rdata.id;
        n_d     = cnt_q;
        i_d     = '0;
        state_d = S_INIT;
      end
      S_DONE: begin
        out_valid_d              = 1'b1;
        out_data_d.total_cost    = fail_q ? '0 : res_q;
        out_data_d.unreachable   = fail_q;
        out_data_d.edges_dropped = ovf_q;
        state_d                  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (adv_min) begin
      e_d = e_q + msa_pkg::EdgeCntW'(1);
      if (e_last) begin
        i_d     = '0;
        state_d = S_WALK_START;
      end else begin
        state_d = S_MIN_RD;
      end
    end

    if (adv_walk) begin
      i_d = i_q + msa_pkg::CntW'(1);
      if (i_last) begin
        i_d     = '0;
        state_d = (cnt_d == '0) ? S_DONE : S_RELAB_RD;
      end else begin
        state_d = S_WALK_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= msa_pkg::CntW'(1);
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
      e_q          <= '0;
      i_q          <= '0;
      n_q          <= msa_pkg::CntW'(1);
      cnt_q        <= '0;
      v_q          <= '0;
      u_q          <= '0;
      root_q       <= '0;
      idu_q        <= '0;
      res_q        <= '0;
      fail_q       <= 1'b0;
      first_q      <= 1'b0;
      wrk_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      edge_total_q <= edge_total_d;
      ovf_q        <= ovf_d;
      e_q          <= e_d;
      i_q          <= i_d;
      n_q          <= n_d;
      cnt_q        <= cnt_d;
      v_q          <= v_d;
      u_q          <= u_d;
      root_q       <= root_d;
      idu_q        <= idu_d;
      res_q        <= res_d;
      fail_q       <= fail_d;
      first_q      <= first_d;
      wrk_q        <= wrk_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

endmodule

// File: hdl/msa_checker.sv
// Port-level checks of the minimum arborescence solver, bound to its top level.
module msa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input msa_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input msa_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unreachable |-> out_data_o.total_cost == '0)
    else $error("unreachable result carries a cost");

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.command == msa_pkg::CMD_SOLVE |=> !in_ready_o)
    else $error("input taken right after a solve transfer");

  a_solve_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.command == msa_pkg::CMD_SOLVE |->
      !out_valid_o || out_ready_i)
    else $error("solve taken while a result is stuck");

endmodule

bind minimum_arborescence_solver_top msa_checker u_msa_checker (.*);
